/* sv/cmc_pkg.sv */
// shared types, codes and constants for the card machine cpu
// no dependencies; used by cmc_decode and card_machine_cpu
package cmc_pkg;

    localparam int ADDR_W = 7;
    localparam int WORD_W = 32;
    localparam int MEM_WORDS_DEF = 100;
    localparam int CARD_CHARS_DEF = 40;

    // host request opcodes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_CARD  = 2'd1;
    localparam logic [1:0] OP_STEP  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    // result kinds
    localparam logic [2:0] KIND_DONE   = 3'd0;
    localparam logic [2:0] KIND_PRINT  = 3'd1;
    localparam logic [2:0] KIND_NEED   = 3'd2;
    localparam logic [2:0] KIND_HALTED = 3'd3;
    localparam logic [2:0] KIND_ERROR  = 3'd4;

    // characters
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [WORD_W-1:0] UNDERSCORE_WORD = {4{CH_UNDER}};

    // two-character instruction mnemonics
    localparam logic [15:0] MN_GD = 16'h4744;
    localparam logic [15:0] MN_PD = 16'h5044;
    localparam logic [15:0] MN_LR = 16'h4C52;
    localparam logic [15:0] MN_SR = 16'h5352;
    localparam logic [15:0] MN_CR = 16'h4352;
    localparam logic [15:0] MN_BT = 16'h4254;

    typedef logic [2:0] instr_t;
    localparam instr_t INSTR_NONE = 3'd0;
    localparam instr_t INSTR_GD   = 3'd1;
    localparam instr_t INSTR_PD   = 3'd2;
    localparam instr_t INSTR_LR   = 3'd3;
    localparam instr_t INSTR_SR   = 3'd4;
    localparam instr_t INSTR_CR   = 3'd5;
    localparam instr_t INSTR_BT   = 3'd6;

    typedef struct packed {
        logic              halt;
        logic              addr_ok;
        instr_t            instr;
        logic [ADDR_W-1:0] addr;
    } decode_t;

endpackage

/* sv/cmc_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module cmc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 100
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/cmc_decode.sv */
// instruction decoder: mnemonic match, halt check and two-digit address
// depends on cmc_pkg
module cmc_decode #(
    parameter int MEM_WORDS = cmc_pkg::MEM_WORDS_DEF
) (
    input  logic [cmc_pkg::WORD_W-1:0] ir,
    output cmc_pkg::decode_t           dec
);

    localparam logic [cmc_pkg::ADDR_W-1:0] MEM_W = cmc_pkg::ADDR_W'(MEM_WORDS);

    logic [7:0]                  c0;
    logic [7:0]                  d0;
    logic [7:0]                  d1;
    logic                        digits_ok;
    logic [cmc_pkg::ADDR_W-1:0]  tens;
    logic [cmc_pkg::ADDR_W-1:0]  value;

    assign c0 = ir[31:24];
    assign d0 = ir[15:8];
    assign d1 = ir[7:0];

    assign digits_ok = (d0 >= cmc_pkg::CH_ZERO) && (d0 <= cmc_pkg::CH_NINE)
                    && (d1 >= cmc_pkg::CH_ZERO) && (d1 <= cmc_pkg::CH_NINE);

    // digit value is the low nibble of an ascii digit; times ten as 8x + 2x
    assign tens  = {d0[3:0], 3'b000} + {2'b00, d0[3:0], 1'b0};
    assign value = tens + {3'b000, d1[3:0]};

    always_comb
    begin
        dec.halt    = (c0 == cmc_pkg::CH_H);
        dec.addr_ok = digits_ok && (value < MEM_W);
        dec.addr    = value;
        unique case (ir[31:16])
            cmc_pkg::MN_GD: dec.instr = cmc_pkg::INSTR_GD;
            cmc_pkg::MN_PD: dec.instr = cmc_pkg::INSTR_PD;
            cmc_pkg::MN_LR: dec.instr = cmc_pkg::INSTR_LR;
            cmc_pkg::MN_SR: dec.instr = cmc_pkg::INSTR_SR;
            cmc_pkg::MN_CR: dec.instr = cmc_pkg::INSTR_CR;
            cmc_pkg::MN_BT: dec.instr = cmc_pkg::INSTR_BT;
            default:        dec.instr = cmc_pkg::INSTR_NONE;
        endcase
    end

endmodule

/* sv/card_machine_cpu.sv */
// card machine cpu top level: request sequencer, machine registers, output register
// depends on cmc_pkg, cmc_ram, cmc_decode
//
// usage: one request channel (in_valid/in_ready with opcode, address, word_data,
// char_count, card_end) and one result channel (out_valid/out_ready with kind,
// print_word, last, program_counter, condition). a request is taken only while
// the sequencer is idle; it then runs through the single word memory port and
// posts its results into one output register.
// load and clear requests go from dispatch straight to the result; a card word
// reads and merges the stored word while a card is pending; a step fetches no
// instruction when halted or waiting for a card, and LR and CR read memory twice;
// a print step reads the memory port once per printed word (10 words by default).
// the next request is taken as soon as the sequencer is idle again, even while
// the last result still sits in the output register.
// when the receiver stalls, the sequencer waits with the pending result and the
// rest of a print block resumes one word per cycle once out_ready returns.
// reset clears the machine registers and marks every memory word as unwritten,
// which reads back as underscores; there is no clearing pass, so requests are
// taken right after reset. a clear-job request does the same.
module card_machine_cpu #(
    parameter int MEM_WORDS  = cmc_pkg::MEM_WORDS_DEF,
    parameter int CARD_CHARS = cmc_pkg::CARD_CHARS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  opcode,
    input  logic [cmc_pkg::ADDR_W-1:0]  address,
    input  logic [cmc_pkg::WORD_W-1:0]  word_data,
    input  logic [2:0]                  char_count,
    input  logic                        card_end,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [2:0]                  kind,
    output logic [cmc_pkg::WORD_W-1:0]  print_word,
    output logic                        last,
    output logic [cmc_pkg::ADDR_W-1:0]  program_counter,
    output logic                        condition
);

    localparam int AW     = cmc_pkg::ADDR_W;
    localparam int WW     = cmc_pkg::WORD_W;
    localparam int RAM_AW = $clog2(MEM_WORDS);
    localparam int WPC    = CARD_CHARS / 4;
    localparam int LEFT_W = $clog2(WPC + 1);
    localparam logic [AW-1:0]     MEM_W    = AW'(MEM_WORDS);
    localparam logic [AW-1:0]     MEM_LAST = AW'(MEM_WORDS - 1);
    localparam logic [LEFT_W-1:0] WPC_L    = LEFT_W'(WPC);
    localparam logic [LEFT_W-1:0] WPC_LAST = LEFT_W'(WPC - 1);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_CARD_RD  = 3'd2;
    localparam logic [2:0] S_FETCH    = 3'd3;
    localparam logic [2:0] S_OPER     = 3'd4;
    localparam logic [2:0] S_PRINT    = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    function automatic logic [AW-1:0] wrap_next(input logic [AW-1:0] a);
        return (a == MEM_LAST) ? '0 : a + AW'(1);
    endfunction

    function automatic logic [WW-1:0] printable(input logic [WW-1:0] w);
        logic [WW-1:0] r;
        r = w;
        for (int i = 0; i < 4; i++)
        begin
            if (w[8*i +: 8] == cmc_pkg::CH_UNDER)
            begin
                r[8*i +: 8] = cmc_pkg::CH_SPACE;
            end
        end
        return r;
    endfunction

    // leading characters of the card word replace the stored ones
    function automatic logic [WW-1:0] merge_card(input logic [WW-1:0] old,
                                                 input logic [WW-1:0] data,
                                                 input logic [2:0]    cnt);
        logic [WW-1:0] r;
        r = old;
        for (int i = 0; i < 4; i++)
        begin
            if (3'(i) < cnt)
            begin
                r[WW-1-8*i -: 8] = data[WW-1-8*i -: 8];
            end
        end
        return r;
    endfunction

    logic [2:0]          state_reg, state_next;
    logic [MEM_WORDS-1:0] mem_valid_reg, mem_valid_next;
    logic                rd_valid_reg;
    logic [WW-1:0]       greg_reg, greg_next;
    logic [AW-1:0]       pc_reg, pc_next;
    logic                flag_reg, flag_next;
    logic                halt_reg, halt_next;
    logic                card_pend_reg, card_pend_next;
    logic [AW-1:0]       card_ptr_reg, card_ptr_next;
    logic [LEFT_W-1:0]   card_left_reg, card_left_next;
    logic [AW-1:0]       print_addr_reg, print_addr_next;
    logic [LEFT_W-1:0]   print_cnt_reg, print_cnt_next;
    cmc_pkg::instr_t     instr_reg, instr_next;
    logic [2:0]          res_kind_reg, res_kind_next;

    logic [1:0]          in_op_reg;
    logic [AW-1:0]       in_addr_reg;
    logic [WW-1:0]       in_data_reg;
    logic [2:0]          in_cnt_reg;
    logic                in_end_reg;

    logic                out_valid_reg, out_valid_next;
    logic [2:0]          kind_reg, kind_next;
    logic [WW-1:0]       print_word_reg, print_word_next;
    logic                last_reg, last_next;
    logic [AW-1:0]       pc_out_reg;
    logic                cond_out_reg;

    logic                accept;
    logic                out_free;
    logic                out_load;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [WW-1:0]       ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [WW-1:0]       ram_rdata;
    logic [WW-1:0]       word_eff;
    logic                clear_job;
    logic [2:0]          cnt_clamp;
    logic [LEFT_W-1:0]   left_dec;
    logic                card_more;
    cmc_pkg::decode_t    dec;

    cmc_ram #(
        .WIDTH (WW),
        .DEPTH (MEM_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr[RAM_AW-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr[RAM_AW-1:0]),
        .rdata (ram_rdata)
    );

    // unwritten words read as underscores
    assign word_eff = rd_valid_reg ? ram_rdata : cmc_pkg::UNDERSCORE_WORD;

    cmc_decode #(
        .MEM_WORDS (MEM_WORDS)
    ) u_decode (
        .ir  (word_eff),
        .dec (dec)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign cnt_clamp = (in_cnt_reg > 3'd4) ? 3'd4 : in_cnt_reg;
    assign left_dec  = (card_left_reg != '0) ? card_left_reg - LEFT_W'(1) : '0;
    assign card_more = !in_end_reg && (left_dec != '0);

    always_comb
    begin
        state_next      = state_reg;
        greg_next       = greg_reg;
        pc_next         = pc_reg;
        flag_next       = flag_reg;
        halt_next       = halt_reg;
        card_pend_next  = card_pend_reg;
        card_ptr_next   = card_ptr_reg;
        card_left_next  = card_left_reg;
        print_addr_next = print_addr_reg;
        print_cnt_next  = print_cnt_reg;
        instr_next      = instr_reg;
        res_kind_next   = res_kind_reg;
        out_load        = 1'b0;
        kind_next       = kind_reg;
        print_word_next = print_word_reg;
        last_next       = last_reg;
        ram_we          = 1'b0;
        ram_waddr       = in_addr_reg;
        ram_wdata       = in_data_reg;
        ram_re          = 1'b0;
        ram_raddr       = pc_reg;
        clear_job       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                res_kind_next = cmc_pkg::KIND_DONE;
                state_next    = S_DONE;
                unique case (in_op_reg)
                    cmc_pkg::OP_LOAD:
                    begin
                        ram_we = (in_addr_reg < MEM_W);
                    end
                    cmc_pkg::OP_CARD:
                    begin
                        if (card_pend_reg)
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = card_ptr_reg;
                            state_next = S_CARD_RD;
                        end
                    end
                    cmc_pkg::OP_STEP:
                    begin
                        if (halt_reg)
                        begin
                            res_kind_next = cmc_pkg::KIND_HALTED;
                        end
                        else if (card_pend_reg)
                        begin
                            res_kind_next = cmc_pkg::KIND_NEED;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = pc_reg;
                            state_next = S_FETCH;
                        end
                    end
                    cmc_pkg::OP_CLEAR:
                    begin
                        clear_job      = 1'b1;
                        greg_next      = '0;
                        pc_next        = '0;
                        flag_next      = 1'b0;
                        halt_next      = 1'b0;
                        card_pend_next = 1'b0;
                        card_ptr_next  = '0;
                        card_left_next = '0;
                    end
                endcase
            end
            S_CARD_RD:
            begin
                ram_we        = (cnt_clamp != 3'd0);
                ram_waddr     = card_ptr_reg;
                ram_wdata     = merge_card(word_eff, in_data_reg, cnt_clamp);
                card_ptr_next = wrap_next(card_ptr_reg);
                if (card_more)
                begin
                    card_left_next = left_dec;
                    res_kind_next  = cmc_pkg::KIND_NEED;
                end
                else
                begin
                    card_pend_next = 1'b0;
                    card_left_next = '0;
                    res_kind_next  = cmc_pkg::KIND_DONE;
                end
                state_next = S_DONE;
            end
            S_FETCH:
            begin
                res_kind_next = cmc_pkg::KIND_DONE;
                state_next    = S_DONE;
                if (dec.halt)
                begin
                    halt_next     = 1'b1;
                    res_kind_next = cmc_pkg::KIND_HALTED;
                end
                else if (!dec.addr_ok)
                begin
                    halt_next     = 1'b1;
                    greg_next     = '0;
                    res_kind_next = cmc_pkg::KIND_ERROR;
                end
                else
                begin
                    unique case (dec.instr)
                        cmc_pkg::INSTR_GD:
                        begin
                            card_pend_next = 1'b1;
                            card_ptr_next  = dec.addr;
                            card_left_next = WPC_L;
                            pc_next        = wrap_next(pc_reg);
                            res_kind_next  = cmc_pkg::KIND_NEED;
                        end
                        cmc_pkg::INSTR_PD:
                        begin
                            pc_next         = wrap_next(pc_reg);
                            print_addr_next = dec.addr;
                            print_cnt_next  = '0;
                            ram_re          = 1'b1;
                            ram_raddr       = dec.addr;
                            state_next      = S_PRINT;
                        end
                        cmc_pkg::INSTR_LR,
                        cmc_pkg::INSTR_CR:
                        begin
                            instr_next = dec.instr;
                            ram_re     = 1'b1;
                            ram_raddr  = dec.addr;
                            state_next = S_OPER;
                        end
                        cmc_pkg::INSTR_SR:
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = dec.addr;
                            ram_wdata = greg_reg;
                            pc_next   = wrap_next(pc_reg);
                        end
                        cmc_pkg::INSTR_BT:
                        begin
                            pc_next = flag_reg ? dec.addr : wrap_next(pc_reg);
                        end
                        default:
                        begin
                            pc_next = wrap_next(pc_reg);
                        end
                    endcase
                end
            end
            S_OPER:
            begin
                if (instr_reg == cmc_pkg::INSTR_LR)
                begin
                    greg_next = word_eff;
                end
                else
                begin
                    flag_next = (greg_reg == word_eff);
                end
                pc_next    = wrap_next(pc_reg);
                state_next = S_DONE;
            end
            S_PRINT:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    kind_next       = cmc_pkg::KIND_PRINT;
                    print_word_next = printable(word_eff);
                    last_next       = (print_cnt_reg == WPC_LAST);
                    if (print_cnt_reg == WPC_LAST)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // fetch the next word while this one goes out
                        print_addr_next = wrap_next(print_addr_reg);
                        print_cnt_next  = print_cnt_reg + LEFT_W'(1);
                        ram_re          = 1'b1;
                        ram_raddr       = wrap_next(print_addr_reg);
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    kind_next       = res_kind_reg;
                    print_word_next = '0;
                    last_next       = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mem_valid_next = mem_valid_reg;
        if (clear_job)
        begin
            mem_valid_next = '0;
        end
        else if (ram_we)
        begin
            mem_valid_next[ram_waddr[RAM_AW-1:0]] = 1'b1;
        end
    end

    assign out_valid_next = out_load || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mem_valid_reg <= '0;
            greg_reg      <= '0;
            pc_reg        <= '0;
            flag_reg      <= 1'b0;
            halt_reg      <= 1'b0;
            card_pend_reg <= 1'b0;
            card_ptr_reg  <= '0;
            card_left_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mem_valid_reg <= mem_valid_next;
            greg_reg      <= greg_next;
            pc_reg        <= pc_next;
            flag_reg      <= flag_next;
            halt_reg      <= halt_next;
            card_pend_reg <= card_pend_next;
            card_ptr_reg  <= card_ptr_next;
            card_left_reg <= card_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_op_reg   <= opcode;
            in_addr_reg <= address;
            in_data_reg <= word_data;
            in_cnt_reg  <= char_count;
            in_end_reg  <= card_end;
        end
        if (ram_re)
        begin
            rd_valid_reg <= mem_valid_reg[ram_raddr[RAM_AW-1:0]];
        end
        if (out_load)
        begin
            pc_out_reg   <= pc_reg;
            cond_out_reg <= flag_reg;
        end
        print_addr_reg <= print_addr_next;
        print_cnt_reg  <= print_cnt_next;
        instr_reg      <= instr_next;
        res_kind_reg   <= res_kind_next;
        kind_reg       <= kind_next;
        print_word_reg <= print_word_next;
        last_reg       <= last_next;
    end

    assign out_valid       = out_valid_reg;
    assign kind            = kind_reg;
    assign print_word      = print_word_reg;
    assign last            = last_reg;
    assign program_counter = pc_out_reg;
    assign condition       = cond_out_reg;

`ifndef SYNTHESIS
    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg < MEM_W)
        else $error("instruction counter out of range");

    a_card_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        card_ptr_reg < MEM_W)
        else $error("card pointer out of range");

    a_card_left: assert property (@(posedge clk) disable iff (!rst_n)
        card_pend_reg |-> (card_left_reg != '0))
        else $error("card pending with no words left");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free) |=> (out_valid && last && print_word == '0))
        else $error("single result not marked last");

    a_no_write_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("memory port read and write in the same cycle");
`endif

endmodule
